FILE: hdl/ckc_pkg.sv
// package: shared types and constants for the counted key cache
package ckc_pkg;
    localparam int KEY_W = 64;
    localparam int CNT_W = 16;
    localparam int CAP_W = 6;
    localparam logic [CAP_W-1:0] RESET_CAP = 6'd20;
    localparam logic [CAP_W-1:0] MIN_CAP = 6'd10;
    localparam int SORT_MIN = 10;
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    // slot cell operations
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;

    typedef struct packed {
        logic cmd;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic hit;
        logic [CNT_W-1:0] hit_count;
        logic evicted;
    } t_rsp;
endpackage

FILE: hdl/ckc_if.sv
// interface: valid/ready channel carrying one word
interface ckc_if #(parameter int W = 8) (input logic i_clk);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/counted_key_cache_with_partial_sort.sv
// top level: age-ordered counted key table built from a chain of slot cells
//  channel | dir | words                      | handshake
//  req     | in  | cmd, key                   | valid/ready
//  rsp     | out | hit, hit_count, evicted    | valid/ready
//  cfg     | in  | capacity at address 0      | apb, pready high
// the word is accepted in the idle state; then lookup: search, reply
// insert hit: search with compaction, append, reply
// insert miss: search, occupancy/3 odd-even sort passes above 10 entries, evict,
//   append, reply
// synchronous active-low reset empties the table; no clearing pass
// the request side is held off while an item is in work or its reply waits
module counted_key_cache_with_partial_sort #(
    parameter int MAX_ENTRIES = 32,
    parameter int KEY_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ckc_if.sink   i_req,
    ckc_if.source o_rsp,
    input  logic  psel,
    input  logic  penable,
    input  logic  pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic  pready
);
    import ckc_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int OW = $clog2(MAX_ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SORT, S_EVICT, S_APPEND, S_REPLY} t_state;

    t_state r_state;
    logic [OW-1:0] r_occ;
    logic [CAP_W-1:0] r_cap;
    logic r_cmd, r_hit, r_ev, r_par;
    logic [KEY_BITS-1:0] r_key;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [OW-1:0] r_lo, r_pass;
    logic [CNT_W-1:0] r_out_cnt;

    logic [1:0] w_op [MAX_ENTRIES];
    logic [KEY_BITS-1:0] w_key [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] w_cnt [MAX_ENTRIES];
    logic [KEY_BITS-1:0] w_ik [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] w_ic [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_match;
    logic w_found;
    logic [IW-1:0] w_fpos;
    logic [OW-1:0] w_lim;
    logic [CAP_W-1:0] w_capc;
    logic [OW-1:0] w_third;
    logic w_evict;

    // chain of slot cells, each reads its newer neighbor
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        ckc_cell #(.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) u_cell (
            .i_clk(i_clk), .i_op(w_op[g]), .i_key(w_ik[g]), .i_cnt(w_ic[g]),
            .i_nb_key(w_key[(g + 1) % MAX_ENTRIES]),
            .i_nb_cnt(w_cnt[(g + 1) % MAX_ENTRIES]),
            .i_cmp_key(r_key), .o_match(w_match[g]), .o_key(w_key[g]), .o_cnt(w_cnt[g])
        );
    end

    // effective limit
    always_comb begin
        w_capc = (r_cap < MIN_CAP) ? MIN_CAP : r_cap;
        w_lim = (32'(w_capc) > MAX_ENTRIES) ? OW'(MAX_ENTRIES) : OW'(w_capc);
    end

    // a third of the occupancy by reciprocal multiply, exact below 2048
    assign w_third = OW'((32'(r_occ) * 32'd683) >> 11);

    // oldest entry goes when the table is at its limit
    assign w_evict = (r_occ >= w_lim) && (r_occ != '0);

    // newest matching valid slot
    always_comb begin
        w_found = 1'b0;
        w_fpos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_match[i] && (OW'(i) < r_occ)) begin
                w_found = 1'b1;
                w_fpos = IW'(i);
            end
        end
    end

    // per-cell operation
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_op[i] = OP_HOLD;
            w_ik[i] = r_key;
            w_ic[i] = r_cnt;
            case (r_state)
                S_SEARCH: begin
                    if (r_cmd == CMD_INSERT && w_found && i >= int'(w_fpos))
                        w_op[i] = OP_TAKE;
                end
                S_EVICT: if (w_evict) w_op[i] = OP_TAKE;
                S_APPEND: if (OW'(i) == r_occ) w_op[i] = OP_LOAD;
                S_SORT: begin
                    // odd-even exchange between slot i and i+1 inside [lo, occ)
                    if ((OW'(i) >= r_lo) && (i + 1 < MAX_ENTRIES)
                        && (OW'(i + 1) < r_occ) && (((OW'(i) - r_lo) & 1) == OW'(r_par))
                        && (w_cnt[i] > w_cnt[(i + 1) % MAX_ENTRIES]))
                        w_op[i] = OP_TAKE;
                    if ((i > 0) && (OW'(i) > r_lo) && (OW'(i) < r_occ)
                        && (((OW'(i) - 1 - r_lo) & 1) == OW'(r_par))
                        && (w_cnt[(i + MAX_ENTRIES - 1) % MAX_ENTRIES] > w_cnt[i])) begin
                        w_op[i] = OP_LOAD;
                        w_ik[i] = w_key[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
                        w_ic[i] = w_cnt[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_REPLY);
    assign o_rsp.data = {r_hit, r_out_cnt, r_ev};
    assign pready = 1'b1;
    assign prdata = 32'(r_cap);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ <= '0;
            r_cap <= RESET_CAP;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
                r_cap <= pwdata[CAP_W-1:0];
                if (r_occ > (((pwdata[CAP_W-1:0] < MIN_CAP) ? OW'(MIN_CAP)
                    : ((32'(pwdata[CAP_W-1:0]) > MAX_ENTRIES) ? OW'(MAX_ENTRIES)
                    : OW'(pwdata[CAP_W-1:0])))))
                    r_occ <= (pwdata[CAP_W-1:0] < MIN_CAP) ? OW'(MIN_CAP)
                        : ((32'(pwdata[CAP_W-1:0]) > MAX_ENTRIES) ? OW'(MAX_ENTRIES)
                        : OW'(pwdata[CAP_W-1:0]));
            end
            case (r_state)
                S_IDLE: if (i_req.valid) begin
                    r_cmd <= i_req.data[KEY_W];
                    r_key <= i_req.data[KEY_BITS-1:0];
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    r_hit <= w_found;
                    r_ev <= 1'b0;
                    if (r_cmd == CMD_LOOKUP) begin
                        r_out_cnt <= w_found ? CNT_W'(w_cnt[w_fpos]) : '0;
                        r_state <= S_REPLY;
                    end else if (w_found) begin
                        r_cnt <= (w_cnt[w_fpos] == CMAX) ? CMAX : w_cnt[w_fpos] + 1'b1;
                        r_out_cnt <= CNT_W'((w_cnt[w_fpos] == CMAX) ? CMAX
                            : w_cnt[w_fpos] + 1'b1);
                        r_occ <= r_occ - 1'b1;
                        r_state <= S_APPEND;
                    end else begin
                        r_cnt <= COUNT_BITS'(1);
                        r_out_cnt <= CNT_W'(1);
                        r_lo <= r_occ - w_third;
                        r_pass <= w_third;
                        r_par <= 1'b0;
                        r_state <= (r_occ > OW'(SORT_MIN)) ? S_SORT : S_EVICT;
                    end
                end
                S_SORT: begin
                    r_par <= ~r_par;
                    r_pass <= r_pass - 1'b1;
                    if (r_pass <= OW'(1)) r_state <= S_EVICT;
                end
                S_EVICT: begin
                    if (w_evict) begin
                        r_ev <= 1'b1;
                        r_occ <= r_occ - 1'b1;
                    end
                    r_state <= S_APPEND;
                end
                S_APPEND: begin
                    if (r_occ < OW'(MAX_ENTRIES)) r_occ <= r_occ + 1'b1;
                    r_state <= S_REPLY;
                end
                S_REPLY: if (o_rsp.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/ckc_cell.sv
// cell: one table slot with compare, shift and sort exchange
module ckc_cell #(
    parameter int KEY_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic [1:0]            i_op,     // hold, load own, take from newer neighbor
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [COUNT_BITS-1:0] i_cnt,
    input  logic [KEY_BITS-1:0]   i_nb_key,
    input  logic [COUNT_BITS-1:0] i_nb_cnt,
    input  logic [KEY_BITS-1:0]   i_cmp_key,
    output logic                  o_match,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [COUNT_BITS-1:0] o_cnt
);
    import ckc_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_cnt;

    // slot storage
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_key <= i_key;
                r_cnt <= i_cnt;
            end
            OP_TAKE: begin
                r_key <= i_nb_key;
                r_cnt <= i_nb_cnt;
            end
            default: begin
            end
        endcase
    end

    assign o_match = (r_key == i_cmp_key);
    assign o_key = r_key;
    assign o_cnt = r_cnt;
endmodule
